/* src/b64d_pkg.sv */
// ============================================================================
// Base64 stream decoder package
// Shared types, constants and the character classifier.
// ============================================================================
package b64d_pkg;

    localparam int B64D_QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

    localparam logic RESULT_DATA   = 1'b0;
    localparam logic RESULT_STATUS = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_SEXTET = 2'd1,
        CMD_PAD    = 2'd2,
        CMD_BAD    = 2'd3
    } cmd_kind_t;

    // One classified item as it travels from the front end to the decoder.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [5:0]  sextet;
        logic        eot;
    } cmd_t;

    // Map a character onto its class and its 6-bit value (either alphabet).
    function automatic cmd_t classify(input logic [7:0] ch, input logic no_char,
                                      input logic eot);
        cmd_t c;
        c.eot    = eot;
        c.kind   = CMD_SEXTET;
        c.sextet = 6'd0;
        if (no_char) begin
            c.kind = CMD_NONE;
        end else if (ch == CHAR_PAD) begin
            c.kind = CMD_PAD;
        end else if (ch inside {[8'h41:8'h5A]}) begin
            c.sextet = 6'(ch - 8'h41);
        end else if (ch inside {[8'h61:8'h7A]}) begin
            c.sextet = 6'(ch - 8'h61 + 8'd26);
        end else if (ch inside {[8'h30:8'h39]}) begin
            c.sextet = 6'(ch - 8'h30 + 8'd52);
        end else if (ch inside {8'h2B, 8'h2D}) begin
            c.sextet = 6'd62;
        end else if (ch inside {8'h2F, 8'h5F}) begin
            c.sextet = 6'd63;
        end else begin
            c.kind = CMD_BAD;
        end
        return c;
    endfunction

endpackage

/* src/b64d_front.sv */
// ============================================================================
// Base64 decoder front end
// Classify each incoming character into a decode command.
// ============================================================================
module b64d_front (
    input  logic [7:0]      s_text_char,
    input  logic            s_no_char,
    input  logic            s_end_of_text,
    output b64d_pkg::cmd_t  cmd
);
    import b64d_pkg::*;

    assign cmd = classify(s_text_char, s_no_char, s_end_of_text);

endmodule

/* src/b64d_queue.sv */
// ============================================================================
// Base64 decoder command queue
// Small FIFO that decouples classification from decoding.
// ============================================================================
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  b64d_pkg::cmd_t  push_cmd,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output b64d_pkg::cmd_t  pop_cmd
);
    import b64d_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/b64d_back.sv */
// ============================================================================
// Base64 decoder back end
// Accumulate sextets, emit bytes and end-of-message status items.
// ============================================================================
module b64d_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  b64d_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_result_kind,
    output logic [7:0]      m_data_byte,
    output logic            m_status,
    output logic            m_final_flag
);
    import b64d_pkg::*;

    logic [11:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        stop_reg, stop_next;
    logic        err_reg, err_next;
    logic        pend_reg, pend_next;
    logic        pend_err_reg, pend_err_next;

    logic        m_valid_reg, m_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic        status_reg, status_next;
    logic        final_reg, final_next;

    logic        slot_free;
    logic        active;
    logic        has_byte;
    logic        err_after;
    logic [11:0] acc_shift;
    logic [3:0]  cnt_plus;
    logic [2:0]  byte_pos;
    logic [7:0]  byte_val;

    assign slot_free = !m_valid_reg || m_ready;
    assign q_pop     = slot_free && !pend_reg && q_valid;
    assign active    = !stop_reg && !err_reg;

    assign acc_shift = {acc_reg[5:0], q_cmd.sextet};
    assign cnt_plus  = {1'b0, cnt_reg} + 4'd6;
    assign byte_pos  = cnt_plus[2:0];
    assign byte_val  = acc_shift[byte_pos +: 8];
    assign has_byte  = active && (q_cmd.kind == CMD_SEXTET) && cnt_plus[3];
    assign err_after = err_reg || (active && (q_cmd.kind == CMD_BAD));

    // Decode state update on pop.
    always_comb begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        stop_next = stop_reg;
        err_next  = err_reg;
        if (q_pop) begin
            if (active) begin
                case (q_cmd.kind)
                    CMD_SEXTET: begin
                        acc_next = acc_shift;
                        cnt_next = cnt_plus[2:0];
                    end
                    CMD_PAD:  stop_next = 1'b1;
                    CMD_BAD:  err_next  = 1'b1;
                    default:  ;
                endcase
            end
            if (q_cmd.eot) begin
                acc_next  = '0;
                cnt_next  = '0;
                stop_next = 1'b0;
                err_next  = 1'b0;
            end
        end
    end

    // Output register: a byte first, a deferred status item next.
    always_comb begin
        m_valid_next  = m_valid_reg;
        kind_next     = kind_reg;
        byte_next     = byte_reg;
        status_next   = status_reg;
        final_next    = final_reg;
        pend_next     = pend_reg;
        pend_err_next = pend_err_reg;
        if (slot_free) begin
            m_valid_next = 1'b0;
            if (pend_reg) begin
                m_valid_next = 1'b1;
                kind_next    = RESULT_STATUS;
                byte_next    = '0;
                status_next  = pend_err_reg;
                final_next   = 1'b1;
                pend_next    = 1'b0;
            end else if (q_pop) begin
                if (has_byte) begin
                    m_valid_next  = 1'b1;
                    kind_next     = RESULT_DATA;
                    byte_next     = byte_val;
                    status_next   = STATUS_OK;
                    final_next    = 1'b0;
                    pend_next     = q_cmd.eot;
                    pend_err_next = err_after;
                end else if (q_cmd.eot) begin
                    m_valid_next = 1'b1;
                    kind_next    = RESULT_STATUS;
                    byte_next    = '0;
                    status_next  = err_after;
                    final_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            cnt_reg     <= '0;
            stop_reg    <= 1'b0;
            err_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            stop_reg    <= stop_next;
            err_reg     <= err_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_err_reg <= pend_err_next;
        kind_reg     <= kind_next;
        byte_reg     <= byte_next;
        status_reg   <= status_next;
        final_reg    <= final_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_data_byte   = byte_reg;
    assign m_status      = status_reg;
    assign m_final_flag  = final_reg;

`ifndef SYNTHESIS
    a_pend_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> m_valid_reg)
        else $error("deferred status without a held output item");

    a_cnt_even: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] == 1'b0)
        else $error("pending bit count is odd");

    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_cmd.eot) |=> (cnt_reg == '0 && !stop_reg && !err_reg))
        else $error("decode state not cleared at end of message");

    a_no_pop_while_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !q_pop)
        else $error("command popped while a status item is owed");
`endif

endmodule

/* src/base64_stream_decoder_core.sv */
// ============================================================================
// Base64 stream decoder core
// Decode a Base64 character stream into bytes plus an end-of-message status.
// ============================================================================
// Usage: feed one character per item on the s_ channel; both the standard
// ('+', '/') and URL-safe ('-', '_') alphabets decode. Each data byte comes
// out as a result item with m_result_kind = 0. A '=' ends decoding for the
// rest of the message; an invalid character latches an error and the rest
// of the message is dropped. The item with s_end_of_text set produces a
// status item (m_result_kind = 1, m_final_flag = 1, m_status = 1 on error)
// after any byte of that item, and clears the decoder; leftover bits are
// discarded. s_no_char marks an item that carries only the end mark. Rate:
// one item per cycle while m_ready holds; an accepted item is registered in
// the command queue and then in the output register. An item that yields a
// byte and a status stalls the queue until the status follows the byte.
// A small command queue sits between the classifier and the decoder so the
// input side keeps accepting while a result waits at the output.
// ============================================================================
module base64_stream_decoder_core #(
    parameter int QUEUE_DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_char,
    input  logic       s_no_char,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_result_kind,
    output logic [7:0] m_data_byte,
    output logic       m_status,
    output logic       m_final_flag
);
    import b64d_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_not_full;
    logic queue_not_empty;
    logic queue_pop;

    // Classify the character as it arrives.
    b64d_front u_front (
        .s_text_char   (s_text_char),
        .s_no_char     (s_no_char),
        .s_end_of_text (s_end_of_text),
        .cmd           (front_cmd)
    );

    // Hold classified items until the decoder is free.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_cmd  (front_cmd),
        .not_full  (queue_not_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_cmd   (queue_cmd)
    );

    assign s_ready = queue_not_full;

    // Advance the bit accumulator and drive the output register.
    b64d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (queue_not_empty),
        .q_cmd         (queue_cmd),
        .q_pop         (queue_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_data_byte   (m_data_byte),
        .m_status      (m_status),
        .m_final_flag  (m_final_flag)
    );

endmodule
